// ===== rtl/linked_list_node_pool_defines.svh =====
// ----------------------------------------------------------------------------
// Linked-list node pool assertion macros
// Shared concurrent assertion forms for the node pool RTL.
// ----------------------------------------------------------------------------
`ifndef LINKED_LIST_NODE_POOL_DEFINES_SVH
`define LINKED_LIST_NODE_POOL_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define LLNP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define LLNP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/llnp_pkg.sv =====
// ----------------------------------------------------------------------------
// Linked-list node pool package
// Field widths, action and status codes, and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package llnp_pkg;

    // Beat field widths
    localparam int ACT_W      = 3;
    localparam int ANC_W      = 10;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 10;
    localparam int ST_W       = 3;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;

    // Request actions (code seven is unused)
    typedef enum logic [ACT_W-1:0] {
        ACT_CREATE    = 3'd0,
        ACT_INSERT    = 3'd1,
        ACT_DEL_AFTER = 3'd2,
        ACT_APPEND    = 3'd3,
        ACT_DEL_LAST  = 3'd4,
        ACT_DEL_NTH   = 3'd5,
        ACT_SEARCH    = 3'd6
    } t_action;

    // Result status
    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_BAD_INS   = 3'd2,
        ST_BAD_DEL   = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_BAD_POS   = 3'd6
    } t_status;

    // Sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_CR,
        S_PA1,
        S_PA2,
        S_PA3,
        S_DA1,
        S_DA2,
        S_AP_WALK,
        S_DL1,
        S_DL_WALK,
        S_CUT_A,
        S_CUT_B,
        S_DN1,
        S_DN_WALK,
        S_SR_WALK,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/linked_list_node_pool.sv =====
// Append, delete_last, search and delete_nth beyond position one walk the
//   list one node at a time through the single read port of the link memory.
// Throughput: one request at a time; the next is taken once the result is
//   in the output register. After reset a sweep loads the free chain into
//   the link memory, and no request is taken meanwhile.
// ----------------------------------------------------------------------------
// Linked-list node pool
// Value and link memories with a free chain, walked by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linked_list_node_pool_defines.svh"

module linked_list_node_pool #(
    parameter int NODE_COUNT = 512,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // tdata: anchor_index[9:0], item_value[41:10], position[51:42], zero pad
    input  wire logic [llnp_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: action[2:0]
    input  wire logic [llnp_pkg::ACT_W-1:0]      i_s_axis_tuser,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: index_out[9:0], value_out[41:10], found_position[51:42],
    //        head_out[61:52], zero pad
    output logic [llnp_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // tuser: status[2:0]
    output logic [llnp_pkg::ST_W-1:0]            o_m_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready
);

    localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int LW = IW + 1;
    localparam int CW = (IW + 1 > 10) ? IW + 1 : 10;
    localparam logic [LW-1:0] NIL = '1;

    // Memories and their registered read data
    logic [LW-1:0]         r_link [NODE_COUNT];
    logic [VALUE_BITS-1:0] r_vmem [NODE_COUNT];
    logic [LW-1:0]         r_lrd;
    logic [VALUE_BITS-1:0] r_vrd;

    // Sequencer and request state
    llnp_pkg::t_state      r_state, n_state;
    logic [2:0]            r_act, n_act;
    logic [9:0]            r_anc, n_anc;
    logic                  r_ok, n_ok;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [9:0]            r_pos, n_pos;
    logic [IW-1:0]         r_cur, n_cur;
    logic [IW-1:0]         r_q, n_q;
    logic [LW-1:0]         r_lq, n_lq;
    logic [CW-1:0]         r_k, n_k;
    logic [LW-1:0]         r_fh, n_fh;
    logic [IW-1:0]         r_clr, n_clr;

    // Result fields
    logic [2:0]            r_st, n_st;
    logic [LW-1:0]         r_idx, n_idx;
    logic [VALUE_BITS-1:0] r_vout, n_vout;
    logic [CW-1:0]         r_found, n_found;
    logic [9:0]            r_head, n_head;

    // Output register
    logic                  r_ovalid, n_ovalid;
    logic [llnp_pkg::OUT_DATA_W-1:0] r_odata, n_odata;
    logic [2:0]            r_ouser, n_ouser;

    // Memory port controls
    logic                  w_lwe, w_vwe;
    logic [IW-1:0]         w_lwa, w_lra, w_vwa, w_vra;
    logic [LW-1:0]         w_lwd;

    // Decode helpers
    logic                  w_accept, w_fh_nil, w_lrd_nil, w_anc_nil, w_k_lim, w_k_zero;
    logic                  w_hit, w_out_free;
    logic [IW-1:0]         w_fh_idx, w_lrd_idx;
    logic [9:0]            w_in_anc;
    logic [31:0]           w_in_val;

    assign o_s_axis_tready = (r_state == llnp_pkg::S_IDLE);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_anc   = i_s_axis_tdata[9:0];
    assign w_in_val   = i_s_axis_tdata[41:10];
    assign w_fh_nil   = r_fh[LW-1];
    assign w_lrd_nil  = (r_lrd == NIL);
    assign w_anc_nil  = (r_anc == 10'h3FF);
    assign w_k_lim    = (r_k < CW'(NODE_COUNT));
    assign w_k_zero   = (r_k == '0);
    assign w_hit      = (r_vrd == r_val);
    assign w_fh_idx   = r_fh[IW-1:0];
    assign w_lrd_idx  = r_lrd[IW-1:0];
    assign w_out_free = !r_ovalid || i_m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            llnp_pkg::S_CLEAR: begin
                if (r_clr == IW'(NODE_COUNT - 1)) n_state = llnp_pkg::S_IDLE;
            end
            llnp_pkg::S_IDLE: begin
                if (w_accept) n_state = llnp_pkg::S_EXEC;
            end
            llnp_pkg::S_EXEC: begin
                n_state = llnp_pkg::S_DONE;
                case (r_act)
                    llnp_pkg::ACT_CREATE:
                        if (!w_fh_nil) n_state = llnp_pkg::S_CR;
                    llnp_pkg::ACT_INSERT:
                        if (r_ok && !w_fh_nil) n_state = llnp_pkg::S_PA1;
                    llnp_pkg::ACT_DEL_AFTER:
                        if (r_ok) n_state = llnp_pkg::S_DA1;
                    llnp_pkg::ACT_APPEND:
                        if (r_ok) n_state = llnp_pkg::S_AP_WALK;
                    llnp_pkg::ACT_DEL_LAST:
                        if (r_ok) n_state = llnp_pkg::S_DL1;
                    llnp_pkg::ACT_DEL_NTH: begin
                        if (r_pos != '0 && r_ok)
                            n_state = (r_pos == 10'd1) ? llnp_pkg::S_DN1
                                                       : llnp_pkg::S_DN_WALK;
                    end
                    llnp_pkg::ACT_SEARCH:
                        if (r_ok) n_state = llnp_pkg::S_SR_WALK;
                    default: n_state = llnp_pkg::S_DONE;
                endcase
            end
            llnp_pkg::S_CR:    n_state = llnp_pkg::S_DONE;
            llnp_pkg::S_PA1:   n_state = llnp_pkg::S_PA2;
            llnp_pkg::S_PA2:   n_state = llnp_pkg::S_PA3;
            llnp_pkg::S_PA3:   n_state = llnp_pkg::S_DONE;
            llnp_pkg::S_DA1:   n_state = w_lrd_nil ? llnp_pkg::S_DONE : llnp_pkg::S_DA2;
            llnp_pkg::S_DA2:   n_state = llnp_pkg::S_CUT_A;
            llnp_pkg::S_AP_WALK: begin
                if (!(w_k_lim && !w_lrd_nil))
                    n_state = w_fh_nil ? llnp_pkg::S_DONE : llnp_pkg::S_PA1;
            end
            llnp_pkg::S_DL1:   n_state = w_lrd_nil ? llnp_pkg::S_DONE : llnp_pkg::S_DL_WALK;
            llnp_pkg::S_DL_WALK: begin
                if (!(w_k_lim && !w_lrd_nil)) n_state = llnp_pkg::S_CUT_A;
            end
            llnp_pkg::S_CUT_A: n_state = llnp_pkg::S_CUT_B;
            llnp_pkg::S_CUT_B: n_state = llnp_pkg::S_DONE;
            llnp_pkg::S_DN1:   n_state = llnp_pkg::S_DONE;
            llnp_pkg::S_DN_WALK: begin
                if (w_lrd_nil)     n_state = llnp_pkg::S_DONE;
                else if (w_k_zero) n_state = llnp_pkg::S_DA2;
            end
            llnp_pkg::S_SR_WALK: begin
                if (w_hit || !w_k_lim || w_lrd_nil) n_state = llnp_pkg::S_DONE;
            end
            llnp_pkg::S_DONE: begin
                if (w_out_free) n_state = llnp_pkg::S_IDLE;
            end
            default: n_state = llnp_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory port controls
    always_comb begin
        n_act = r_act;   n_anc = r_anc;   n_ok = r_ok;     n_val = r_val;
        n_pos = r_pos;   n_cur = r_cur;   n_q = r_q;       n_lq = r_lq;
        n_k = r_k;       n_fh = r_fh;     n_clr = r_clr;
        n_st = r_st;     n_idx = r_idx;   n_vout = r_vout;
        n_found = r_found; n_head = r_head;
        n_ovalid = r_ovalid; n_odata = r_odata; n_ouser = r_ouser;
        w_lwe = 1'b0;    w_lwa = r_cur;   w_lwd = NIL;     w_lra = r_cur;
        w_vwe = 1'b0;    w_vwa = r_q;     w_vra = r_cur;

        // Output beat leaves
        if (r_ovalid && i_m_axis_tready) n_ovalid = 1'b0;

        unique case (r_state)
            // Build the free chain, one link a cycle
            llnp_pkg::S_CLEAR: begin
                w_lwe = 1'b1;
                w_lwa = r_clr;
                w_lwd = (r_clr == IW'(NODE_COUNT - 1)) ? NIL : LW'(r_clr) + LW'(1);
                n_clr = r_clr + IW'(1);
            end
            llnp_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_act   = i_s_axis_tuser;
                    n_anc   = w_in_anc;
                    n_ok    = !w_in_anc[9] && ({23'd0, w_in_anc[8:0]} < NODE_COUNT);
                    n_val   = VALUE_BITS'({{32{w_in_val[31]}}, w_in_val});
                    n_pos   = i_s_axis_tdata[51:42];
                    n_cur   = IW'(w_in_anc[8:0]);
                    n_st    = llnp_pkg::ST_OK;
                    n_idx   = NIL;
                    n_vout  = '0;
                    n_found = '0;
                    n_head  = w_in_anc;
                end
            end
            // Operand checks and first read
            llnp_pkg::S_EXEC: begin
                case (r_act)
                    llnp_pkg::ACT_CREATE: begin
                        if (w_fh_nil) n_st = llnp_pkg::ST_OVERFLOW;
                        n_q   = w_fh_idx;
                        w_lra = w_fh_idx;
                    end
                    llnp_pkg::ACT_INSERT: begin
                        if (!r_ok)         n_st = llnp_pkg::ST_BAD_INS;
                        else if (w_fh_nil) n_st = llnp_pkg::ST_OVERFLOW;
                        n_q   = w_fh_idx;
                        w_lra = w_fh_idx;
                    end
                    llnp_pkg::ACT_DEL_AFTER: begin
                        if (!r_ok) n_st = llnp_pkg::ST_BAD_DEL;
                    end
                    llnp_pkg::ACT_APPEND: begin
                        if (w_anc_nil)  n_st = llnp_pkg::ST_EMPTY;
                        else if (!r_ok) n_st = llnp_pkg::ST_BAD_INS;
                        n_k = CW'(1);
                    end
                    llnp_pkg::ACT_DEL_LAST: begin
                        if (w_anc_nil)  n_st = llnp_pkg::ST_EMPTY;
                        else if (!r_ok) n_st = llnp_pkg::ST_BAD_DEL;
                        n_k = CW'(1);
                    end
                    llnp_pkg::ACT_DEL_NTH: begin
                        if (r_pos == '0)    n_st = llnp_pkg::ST_BAD_POS;
                        else if (w_anc_nil) n_st = llnp_pkg::ST_EMPTY;
                        else if (!r_ok)     n_st = llnp_pkg::ST_BAD_POS;
                        n_k = CW'(r_pos) - CW'(2);
                    end
                    llnp_pkg::ACT_SEARCH: begin
                        if (!r_ok) n_st = llnp_pkg::ST_NOT_FOUND;
                        n_k = CW'(1);
                    end
                    default: n_st = llnp_pkg::ST_OK;
                endcase
            end
            // Create: new node ends its own list
            llnp_pkg::S_CR: begin
                n_fh   = r_lrd;
                w_lwe  = 1'b1;
                w_lwa  = r_q;
                w_lwd  = NIL;
                w_vwe  = 1'b1;
                n_idx  = {1'b0, r_q};
                n_head = 10'(r_q);
            end
            // Put after node r_cur: pop free node, then splice it in
            llnp_pkg::S_PA1: begin
                n_fh  = r_lrd;
                w_lra = r_cur;
            end
            llnp_pkg::S_PA2: begin
                w_lwe = 1'b1;
                w_lwa = r_q;
                w_lwd = r_lrd;
                w_vwe = 1'b1;
            end
            llnp_pkg::S_PA3: begin
                w_lwe = 1'b1;
                w_lwa = r_cur;
                w_lwd = {1'b0, r_q};
                n_idx = {1'b0, r_q};
            end
            // Delete after: fetch successor and its link
            llnp_pkg::S_DA1: begin
                if (w_lrd_nil) n_st = llnp_pkg::ST_BAD_DEL;
                n_q   = w_lrd_idx;
                w_lra = w_lrd_idx;
            end
            llnp_pkg::S_DA2: begin
                n_lq = r_lrd;
            end
            // Walk to the tail
            llnp_pkg::S_AP_WALK: begin
                if (w_k_lim && !w_lrd_nil) begin
                    n_cur = w_lrd_idx;
                    n_k   = r_k + CW'(1);
                    w_lra = w_lrd_idx;
                end else begin
                    if (w_fh_nil) n_st = llnp_pkg::ST_OVERFLOW;
                    n_q   = w_fh_idx;
                    w_lra = w_fh_idx;
                end
            end
            // Walk to the node before the tail
            llnp_pkg::S_DL1: begin
                if (w_lrd_nil) n_st = llnp_pkg::ST_BAD_DEL;
                n_q   = w_lrd_idx;
                w_lra = w_lrd_idx;
            end
            llnp_pkg::S_DL_WALK: begin
                if (w_k_lim && !w_lrd_nil) begin
                    n_cur = r_q;
                    n_q   = w_lrd_idx;
                    n_k   = r_k + CW'(1);
                    w_lra = w_lrd_idx;
                end else begin
                    n_lq = r_lrd;
                end
            end
            // Unlink r_q after r_cur and push it onto the free chain
            llnp_pkg::S_CUT_A: begin
                w_lwe = 1'b1;
                w_lwa = r_cur;
                w_lwd = r_lq;
                w_vra = r_q;
            end
            llnp_pkg::S_CUT_B: begin
                w_lwe  = 1'b1;
                w_lwa  = r_q;
                w_lwd  = r_fh;
                n_fh   = {1'b0, r_q};
                n_vout = r_vrd;
            end
            // Delete the head node
            llnp_pkg::S_DN1: begin
                w_lwe  = 1'b1;
                w_lwa  = r_cur;
                w_lwd  = r_fh;
                n_fh   = {1'b0, r_cur};
                n_head = 10'($signed(r_lrd));
                n_vout = r_vrd;
            end
            // Walk to the node before the one to delete
            llnp_pkg::S_DN_WALK: begin
                if (w_lrd_nil) begin
                    n_st = llnp_pkg::ST_BAD_POS;
                end else if (w_k_zero) begin
                    n_q   = w_lrd_idx;
                    w_lra = w_lrd_idx;
                end else begin
                    n_cur = w_lrd_idx;
                    n_k   = r_k - CW'(1);
                    w_lra = w_lrd_idx;
                end
            end
            // Compare one node a cycle
            llnp_pkg::S_SR_WALK: begin
                if (w_hit) begin
                    n_idx   = {1'b0, r_cur};
                    n_found = r_k;
                end else if (!w_k_lim || w_lrd_nil) begin
                    n_st = llnp_pkg::ST_NOT_FOUND;
                end else begin
                    n_cur = w_lrd_idx;
                    n_k   = r_k + CW'(1);
                    w_lra = w_lrd_idx;
                    w_vra = w_lrd_idx;
                end
            end
            // Hand the result to the output register
            llnp_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ouser  = r_st;
                    n_odata  = {2'b00, r_head, 10'(r_found), 32'(r_vout),
                                10'($signed(r_idx))};
                end
            end
            default: n_st = r_st;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= llnp_pkg::S_CLEAR;
            r_clr    <= '0;
            r_fh     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_fh     <= n_fh;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_act <= n_act;   r_anc <= n_anc;   r_ok <= n_ok;     r_val <= n_val;
        r_pos <= n_pos;   r_cur <= n_cur;   r_q <= n_q;       r_lq <= n_lq;
        r_k <= n_k;       r_st <= n_st;     r_idx <= n_idx;   r_vout <= n_vout;
        r_found <= n_found; r_head <= n_head;
        r_odata <= n_odata; r_ouser <= n_ouser;
    end

    // Link memory
    always_ff @(posedge i_clk) begin
        if (w_lwe) r_link[w_lwa] <= w_lwd;
        r_lrd <= r_link[w_lra];
    end

    // Value memory
    always_ff @(posedge i_clk) begin
        if (w_vwe) r_vmem[w_vwa] <= r_val;
        r_vrd <= r_vmem[w_vra];
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    `LLNP_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_s_axis_tready, "ready after accept")
    `LLNP_ASSERT_IMP(a_free_head_range, i_clk, i_rst_n, 1'b1, w_fh_nil || (r_fh < LW'(NODE_COUNT)), "free head out of pool")
    `LLNP_ASSERT_IMP(a_no_write_idle, i_clk, i_rst_n, r_state == llnp_pkg::S_IDLE, !w_lwe && !w_vwe, "memory write while idle")
    `LLNP_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, (r_state == llnp_pkg::S_DONE) && w_out_free, o_m_axis_tvalid && (r_state == llnp_pkg::S_IDLE), "result not loaded")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Linked-list node pool testbench
// Streams pool requests into the block and scores every result beat against
// an in-bench model of the value store, link store and free chain. A short
// directed set covers each action and its error paths. Random traffic then
// alternates growth phases, rich in inserts and appends, with shrink phases
// that cut them back. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int            POOL_SIZE  = 512;
    localparam int            NIL_NODE   = -1;
    localparam logic [2:0]    ACT_UNUSED = 3'd7;
    localparam int            STALL_MAX  = 20000;
    localparam int            DRAIN_WAIT = 600;
    localparam int            RAND_ITEMS = 1250;

    typedef struct {
        logic [llnp_pkg::ACT_W-1:0]        act;
        logic signed [llnp_pkg::ANC_W-1:0] anc;
        logic [llnp_pkg::VAL_W-1:0]        val;
        logic [llnp_pkg::POS_W-1:0]        pos;
        bit                                hold_off;
    } pool_req_t;

    typedef struct {
        logic [llnp_pkg::ST_W-1:0]         st;
        logic signed [llnp_pkg::ANC_W-1:0] idx;
        logic [llnp_pkg::VAL_W-1:0]        vout;
        logic [llnp_pkg::POS_W-1:0]        fpos;
        logic signed [llnp_pkg::ANC_W-1:0] head;
    } pool_rsp_t;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic [llnp_pkg::IN_DATA_W-1:0]    s_tdata = '0;
    logic [llnp_pkg::ACT_W-1:0]        s_tuser = '0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [llnp_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic [llnp_pkg::ST_W-1:0]         m_tuser;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;

    // Model state of the pool
    int          pool_link [POOL_SIZE];
    logic [31:0] pool_val [POOL_SIZE];
    bit          pool_wr [POOL_SIZE];
    int          free_top;
    bit          unwritten_hit;

    pool_req_t pending_q [$];
    pool_rsp_t rsp_exp_q [$];
    int        list_heads [$];
    int        sent_cnt = 0;
    int        rcv_cnt = 0;
    int        total_items = 0;
    bit        failed = 0;

    linked_list_node_pool uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready)
    );

    always #4 i_clk = ~i_clk;

    // ---- pool model ----
    function automatic logic [31:0] read_val(int n);
        if (!pool_wr[n]) unwritten_hit = 1;
        return pool_val[n];
    endfunction

    function automatic int take_node();
        int q;
        q = free_top;
        if (q < 0 || q >= POOL_SIZE) return NIL_NODE;
        free_top = pool_link[q];
        return q;
    endfunction

    function automatic void release_node(int q);
        pool_link[q] = free_top;
        free_top = q;
    endfunction

    function automatic int link_after(int p, logic [31:0] v);
        int q;
        q = take_node();
        if (q == NIL_NODE) return NIL_NODE;
        pool_val[q] = v;
        pool_wr[q] = 1;
        pool_link[q] = pool_link[p];
        pool_link[p] = q;
        return q;
    endfunction

    function automatic logic [31:0] unlink_after(int p);
        int q;
        logic [31:0] v;
        q = pool_link[p];
        v = read_val(q);
        pool_link[p] = pool_link[q];
        release_node(q);
        return v;
    endfunction

    function automatic pool_rsp_t pool_apply(pool_req_t r);
        pool_rsp_t o;
        int a, cur, idx, head, k, pos;
        bit ok;
        llnp_pkg::t_status st;
        logic [31:0] vout;
        a = int'(r.anc);
        pos = int'(r.pos);
        ok = a >= 0 && a < POOL_SIZE;
        st = llnp_pkg::ST_OK;
        idx = NIL_NODE;
        head = a;
        vout = '0;
        k = 0;
        case (r.act)
            llnp_pkg::ACT_CREATE: begin
                idx = take_node();
                if (idx == NIL_NODE) begin
                    st = llnp_pkg::ST_OVERFLOW;
                end else begin
                    pool_val[idx] = r.val;
                    pool_wr[idx] = 1;
                    pool_link[idx] = NIL_NODE;
                    head = idx;
                end
            end
            llnp_pkg::ACT_INSERT: begin
                if (!ok) begin
                    st = llnp_pkg::ST_BAD_INS;
                end else begin
                    idx = link_after(a, r.val);
                    if (idx == NIL_NODE) st = llnp_pkg::ST_OVERFLOW;
                end
            end
            llnp_pkg::ACT_DEL_AFTER: begin
                if (!ok || pool_link[a] == NIL_NODE) st = llnp_pkg::ST_BAD_DEL;
                else vout = unlink_after(a);
            end
            llnp_pkg::ACT_APPEND: begin
                if (a == NIL_NODE) begin
                    st = llnp_pkg::ST_EMPTY;
                end else if (!ok) begin
                    st = llnp_pkg::ST_BAD_INS;
                end else begin
                    cur = a;
                    for (k = 1; k < POOL_SIZE && pool_link[cur] != NIL_NODE; k++)
                        cur = pool_link[cur];
                    idx = link_after(cur, r.val);
                    if (idx == NIL_NODE) st = llnp_pkg::ST_OVERFLOW;
                end
            end
            llnp_pkg::ACT_DEL_LAST: begin
                if (a == NIL_NODE) begin
                    st = llnp_pkg::ST_EMPTY;
                end else if (!ok) begin
                    st = llnp_pkg::ST_BAD_DEL;
                end else begin
                    cur = a;
                    for (k = 1; k < POOL_SIZE && pool_link[cur] != NIL_NODE
                            && pool_link[pool_link[cur]] != NIL_NODE; k++)
                        cur = pool_link[cur];
                    if (pool_link[cur] == NIL_NODE) st = llnp_pkg::ST_BAD_DEL;
                    else vout = unlink_after(cur);
                end
            end
            llnp_pkg::ACT_DEL_NTH: begin
                if (pos < 1) begin
                    st = llnp_pkg::ST_BAD_POS;
                end else if (a == NIL_NODE) begin
                    st = llnp_pkg::ST_EMPTY;
                end else if (!ok) begin
                    st = llnp_pkg::ST_BAD_POS;
                end else if (pos == 1) begin
                    // removing the head hands back its successor
                    vout = read_val(a);
                    head = pool_link[a];
                    release_node(a);
                end else begin
                    cur = a;
                    for (k = 0; cur != NIL_NODE && k + 2 < pos; k++)
                        cur = pool_link[cur];
                    if (cur == NIL_NODE || pool_link[cur] == NIL_NODE)
                        st = llnp_pkg::ST_BAD_POS;
                    else vout = unlink_after(cur);
                end
            end
            llnp_pkg::ACT_SEARCH: begin
                st = llnp_pkg::ST_NOT_FOUND;
                cur = ok ? a : NIL_NODE;
                for (k = 1; k <= POOL_SIZE && cur != NIL_NODE; k++) begin
                    if (read_val(cur) == r.val) begin
                        st = llnp_pkg::ST_OK;
                        idx = cur;
                        break;
                    end
                    cur = pool_link[cur];
                end
            end
            default: ;
        endcase
        o.st = st;
        o.idx = idx[9:0];
        o.vout = vout;
        o.fpos = (r.act == llnp_pkg::ACT_SEARCH && st == llnp_pkg::ST_OK) ? k[9:0] : '0;
        o.head = head[9:0];
        return o;
    endfunction

    // Run one request through the model; refuse it if it would touch a
    // value entry never written. Returns 1 when queued.
    function automatic bit queue_req(pool_req_t r);
        int          save_link [POOL_SIZE];
        logic [31:0] save_val [POOL_SIZE];
        bit          save_wr [POOL_SIZE];
        int          save_free, a;
        pool_rsp_t   o;
        save_link = pool_link;
        save_val = pool_val;
        save_wr = pool_wr;
        save_free = free_top;
        unwritten_hit = 0;
        o = pool_apply(r);
        if (unwritten_hit) begin
            pool_link = save_link;
            pool_val = save_val;
            pool_wr = save_wr;
            free_top = save_free;
            return 0;
        end
        a = int'(r.anc);
        if (r.act == llnp_pkg::ACT_CREATE && o.st == llnp_pkg::ST_OK)
            list_heads.push_back(int'(o.idx));
        if (r.act == llnp_pkg::ACT_DEL_NTH && o.st == llnp_pkg::ST_OK && r.pos == 1) begin
            foreach (list_heads[i])
                if (list_heads[i] == a) begin
                    if (o.head == -1) list_heads.delete(i);
                    else list_heads[i] = int'(o.head);
                    break;
                end
        end
        pending_q.push_back(r);
        rsp_exp_q.push_back(o);
        total_items++;
        return 1;
    endfunction

    function automatic pool_req_t mk_req(logic [2:0] act, int anc, logic [31:0] val, int pos);
        pool_req_t r;
        r.act = act;
        r.anc = anc[9:0];
        r.val = val;
        r.pos = pos[9:0];
        r.hold_off = 0;
        return r;
    endfunction

    function automatic int gap_len();
        int g;
        g = $urandom_range(0, 99);
        if (g < 60) return 0;
        if (g < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Anchor in a random live list, up to twelve steps in when walk is set, sometimes null or negative
    function automatic int pick_anchor(bit walk);
        int n, s, g;
        g = $urandom_range(0, 99);
        if (g < 3 || list_heads.size() == 0) return NIL_NODE;
        if (g < 6) return -int'($urandom_range(2, 512));
        n = list_heads[$urandom_range(0, list_heads.size() - 1)];
        if (walk) begin
            s = $urandom_range(0, 12);
            while (s > 0 && pool_link[n] != NIL_NODE) begin
                n = pool_link[n];
                s--;
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'hffffffff;
            3, 4: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_pos();
        int g;
        g = $urandom_range(0, 99);
        if (g < 5) return 0;
        if (g < 10) return $urandom_range(512, 1023);
        if (g < 40) return 1;
        return $urandom_range(2, 20);
    endfunction

    // ---- stimulus build ----
    initial begin : build
        pool_req_t r;
        int n, g, tries;
        bit grow;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_link[i] = (i == POOL_SIZE - 1) ? NIL_NODE : i + 1;
            pool_val[i] = '0;
            pool_wr[i] = 0;
        end
        free_top = 0;

        // directed: every action and its operand error paths
        void'(queue_req(mk_req(llnp_pkg::ACT_CREATE, 0, 32'h7fffffff, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_CREATE, 0, 32'h80000000, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_INSERT, 0, 32'h0, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_APPEND, 0, 32'hffffffff, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_SEARCH, 0, 32'hffffffff, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_SEARCH, 0, 32'h12345, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_SEARCH, -1, 32'h0, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_DEL_AFTER, 0, 32'h0, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_DEL_LAST, 0, 32'h0, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_DEL_LAST, 1, 32'h0, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_DEL_NTH, 0, 32'h0, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_DEL_NTH, 0, 32'h0, 1023)));
        void'(queue_req(mk_req(llnp_pkg::ACT_DEL_NTH, -1, 32'h0, 1)));
        void'(queue_req(mk_req(llnp_pkg::ACT_DEL_NTH, -512, 32'h0, 2)));
        void'(queue_req(mk_req(llnp_pkg::ACT_INSERT, -1, 32'h5, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_INSERT, -512, 32'h5, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_DEL_AFTER, -1, 32'h0, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_DEL_AFTER, 1, 32'h0, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_APPEND, -1, 32'h0, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_APPEND, -300, 32'h0, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_DEL_LAST, -1, 32'h0, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_DEL_LAST, -2, 32'h0, 0)));
        void'(queue_req(mk_req(ACT_UNUSED, 7, 32'hdeadbeef, 5)));
        void'(queue_req(mk_req(llnp_pkg::ACT_INSERT, 0, 32'h3, 0)));
        void'(queue_req(mk_req(llnp_pkg::ACT_DEL_NTH, 0, 32'h0, 1)));

        // random: growth phases favour inserts and appends, shrink phases cut them back
        grow = 1;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 200 == 199) grow = !grow;
            tries = 0;
            do begin
                g = $urandom_range(0, 99);
                if (list_heads.size() == 0 || (g < 6 && list_heads.size() < 8))
                    r = mk_req(llnp_pkg::ACT_CREATE, $urandom_range(0, 1023), pick_value(),
                               pick_pos());
                else if (g < 1)
                    r = mk_req(ACT_UNUSED, $urandom_range(0, 1023), $urandom, pick_pos());
                else if (g < (grow ? 55 : 22))
                    r = mk_req(llnp_pkg::ACT_INSERT, pick_anchor(1), pick_value(), pick_pos());
                else if (g < (grow ? 62 : 28))
                    r = mk_req(llnp_pkg::ACT_APPEND, pick_anchor(0), pick_value(), pick_pos());
                else if (g < 75)
                    r = mk_req(llnp_pkg::ACT_SEARCH, pick_anchor(g < 68), pick_value(),
                               pick_pos());
                else if (g < 85)
                    r = mk_req(llnp_pkg::ACT_DEL_AFTER, pick_anchor(1), $urandom, pick_pos());
                else if (g < 90)
                    r = mk_req(llnp_pkg::ACT_DEL_LAST, pick_anchor(0), $urandom, pick_pos());
                else
                    r = mk_req(llnp_pkg::ACT_DEL_NTH, pick_anchor(0), $urandom, pick_pos());
                r.hold_off = (i % 300 == 150);
                tries++;
            end while (!queue_req(r) && tries < 50);
        end
    end

    // ---- reset ----
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---- request driver ----
    int  src_gap = 0;
    bit  src_burst = 0;
    always @(posedge i_clk) begin : driver
        bit nxt_valid;
        pool_req_t r;
        if (i_rst_n) begin
            nxt_valid = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) sent_cnt <= sent_cnt + 1;
            if ($urandom_range(0, 149) == 0) src_burst <= !src_burst;
            if (!nxt_valid) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                end else if (pending_q.size() > 0 && !(pending_q[0].hold_off
                        && sent_cnt + int'(s_tvalid && s_tready) != rcv_cnt)) begin
                    r = pending_q.pop_front();
                    s_tdata <= {4'b0, r.pos, r.val, r.anc};
                    s_tuser <= r.act;
                    nxt_valid = 1;
                    src_gap <= src_burst ? 0 : gap_len();
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // ---- result monitor ----
    bit sink_burst = 0;
    always @(posedge i_clk) begin : monitor
        pool_rsp_t e;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                rcv_cnt <= rcv_cnt + 1;
                if (rsp_exp_q.size() == 0) begin
                    $display("%0t: unexpected result beat tuser=%0d tdata=%h",
                             $realtime, m_tuser, m_tdata);
                    failed = 1;
                end else begin
                    e = rsp_exp_q.pop_front();
                    if (m_tuser !== e.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $realtime, e.st, m_tuser);
                        failed = 1;
                    end
                    if (m_tdata[9:0] !== e.idx) begin
                        $display("%0t: index_out expected %0d actual %0d",
                                 $realtime, e.idx, $signed(m_tdata[9:0]));
                        failed = 1;
                    end
                    if (m_tdata[41:10] !== e.vout) begin
                        $display("%0t: value_out expected %h actual %h",
                                 $realtime, e.vout, m_tdata[41:10]);
                        failed = 1;
                    end
                    if (m_tdata[51:42] !== e.fpos) begin
                        $display("%0t: found_position expected %0d actual %0d",
                                 $realtime, e.fpos, m_tdata[51:42]);
                        failed = 1;
                    end
                    if (m_tdata[61:52] !== e.head) begin
                        $display("%0t: head_out expected %0d actual %0d",
                                 $realtime, e.head, $signed(m_tdata[61:52]));
                        failed = 1;
                    end
                    if (m_tdata[63:62] !== 2'b0) begin
                        $display("%0t: pad expected 0 actual %b",
                                 $realtime, m_tdata[63:62]);
                        failed = 1;
                    end
                end
            end
            if ($urandom_range(0, 149) == 0) sink_burst <= !sink_burst;
            // ready held low for a while at random
            m_tready <= sink_burst ? 1'b1 : (gap_len() == 0);
        end
    end

    // ---- watchdog ----
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("%0t: no beat accepted for %0d cycles", $realtime, STALL_MAX);
            $display("Mismatches found");
            $finish;
        end
    end

    // ---- end of run ----
    initial begin
        @(posedge i_rst_n);
        wait (pending_q.size() == 0 && !s_tvalid && rcv_cnt == total_items);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (rsp_exp_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, rsp_exp_q.size());
            failed = 1;
        end
        if (!failed)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/llnp_pkg.sv
rtl/linked_list_node_pool.sv
tb/testbench.sv
